### src/pfa_pkg.sv
// Shared types, codes and defaults for the per-CPU page free-list allocator.
// No dependencies; the interfaces and the core refer to it by scoped names.
`timescale 1ns / 1ps

package pfa_pkg;

    // Default configuration of the allocator core
    localparam int NUM_CPUS_DEF  = 8;
    localparam int MAX_PAGES_DEF = 32768;
    localparam int PAGE_BITS_DEF = 12;

    // Field widths of the request and response beats
    localparam int CMD_W      = 2;
    localparam int CPU_FLD_W  = 3;
    localparam int ADDR_W     = 32;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // Register indexes and reset values
    localparam logic [CFG_IDX_W-1:0]  CFG_KERNEL_END = 1'b0;
    localparam logic [CFG_IDX_W-1:0]  CFG_PHYS_TOP   = 1'b1;
    localparam logic [CFG_DATA_W-1:0] KERNEL_END_RST = 32'h8002_0000;
    localparam logic [CFG_DATA_W-1:0] PHYS_TOP_RST   = 32'h8800_0000;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_INIT  = 2'd2
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_OOM      = 2'd1,
        ST_BAD_FREE = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC,
        S_FREE,
        S_INIT,
        S_RESP
    } t_state;

endpackage

### src/pfa_req_if.sv
// Request channel of the page allocator: valid/ready plus cmd, cpu, address.
// Depends on pfa_pkg for the field widths.
`timescale 1ns / 1ps

interface pfa_req_if;
    logic                         valid;
    logic                         ready;
    logic [pfa_pkg::CMD_W-1:0]     cmd;
    logic [pfa_pkg::CPU_FLD_W-1:0] cpu;
    logic [pfa_pkg::ADDR_W-1:0]    address;

    modport source (output valid, output cmd, output cpu, output address, input ready);
    modport sink   (input valid, input cmd, input cpu, input address, output ready);
endinterface

### src/pfa_rsp_if.sv
// Response channel of the page allocator: valid/ready plus status, page_address, source_cpu.
// Depends on pfa_pkg for the field widths.
`timescale 1ns / 1ps

interface pfa_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [pfa_pkg::STATUS_W-1:0]  status;
    logic [pfa_pkg::ADDR_W-1:0]    page_address;
    logic [pfa_pkg::CPU_FLD_W-1:0] source_cpu;

    modport source (output valid, output status, output page_address, output source_cpu,
                    input ready);
    modport sink   (input valid, input status, input page_address, input source_cpu,
                    output ready);
endinterface

### src/per_cpu_page_free_list_allocator_core.sv
// Top level of the per-CPU page free-list allocator.
// Depends on pfa_pkg, pfa_req_if, pfa_rsp_if and pfa_ram.
`timescale 1ns / 1ps

// Usage
//   i_req  carries one command per beat: alloc, free or init, the requesting
//          CPU and, for free, the page byte address.
//   o_rsp  returns exactly one beat per request: status, page address and
//          the list the page came from.
//   i_cfg_* writes kernel_end (index 0) or phys_top (index 1); write only
//          while no request is in flight.
// Operation
//   Alloc reads the head page's next link from the link RAM (registered
//   read), free checks the address and, if it passes, writes one link.
//   One request is worked on at a time. Init writes one link per page
//   into the RAM port for N pages, N = min(MAX_PAGES, whole pages from
//   rounded kernel_end to phys_top). Unknown commands answer ok.
// Reset
//   Clears every list head and marks all lists empty; the link RAM keeps
//   garbage until init or free writes it. The configuration registers take their defaults.
// Backpressure
//   A finished response waits in the output register; the next request is
//   still taken and worked up to its commit point, where it holds until
//   the output register frees up.

module per_cpu_page_free_list_allocator_core #(
    parameter int NUM_CPUS  = pfa_pkg::NUM_CPUS_DEF,
    parameter int MAX_PAGES = pfa_pkg::MAX_PAGES_DEF,
    parameter int PAGE_BITS = pfa_pkg::PAGE_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    pfa_req_if.sink                          i_req,
    pfa_rsp_if.source                        o_rsp,
    input  logic                             i_cfg_we,
    input  logic [pfa_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pfa_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int PGN_W     = $clog2(MAX_PAGES);
    localparam int N_W       = PGN_W + 1;
    localparam int LINK_W    = PGN_W + 1;
    localparam int CPU_W     = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int PGF_W     = 33 - PAGE_BITS;
    localparam int EXT_W     = ((PGF_W > PGN_W) ? PGF_W : PGN_W) + 1;
    localparam logic [32:0] PG_MASK  = 33'((64'd1 << PAGE_BITS) - 64'd1);
    localparam logic [33:0] PG_SIZE  = 34'(64'd1 << PAGE_BITS);
    localparam logic [32:0] BASE_RST = ({1'b0, pfa_pkg::KERNEL_END_RST} + PG_MASK) & ~PG_MASK;

    // State and configuration
    pfa_pkg::t_state   r_state, n_state;
    logic [31:0]       r_kernel_end, r_phys_top;
    logic [32:0]       r_base;

    // List heads in flops, next links in RAM
    logic [PGN_W-1:0]  r_head [NUM_CPUS];
    logic [NUM_CPUS-1:0] r_ne;

    // Per-request working registers
    logic [CPU_W-1:0]  r_from, r_cpu;
    logic [PGN_W-1:0]  r_pg;
    logic [31:0]       r_addr;
    logic [32:0]       r_p;
    logic [N_W-1:0]    r_n;
    logic [1:0]        r_res_status;

    // Output register
    logic              r_o_valid;
    logic [1:0]        r_o_status;
    logic [31:0]       r_o_addr;
    logic [2:0]        r_o_src;

    // Link RAM ports
    logic              ram_we, ram_re;
    logic [PGN_W-1:0]  ram_waddr, ram_raddr;
    logic [LINK_W-1:0] ram_wdata, ram_rdata;

    // Control
    logic              accept, slot_free, any_ne;
    logic [pfa_pkg::CPU_FLD_W-1:0] cpu_rem;
    logic [CPU_W-1:0]  cpu_m, from_sel;
    logic              push_en, pop_en, out_load, init_clear;
    logic [CPU_W-1:0]  push_cpu;
    logic [PGN_W-1:0]  push_pg;
    logic [1:0]        out_status;
    logic [31:0]       out_addr;
    logic [2:0]        out_src;
    logic              free_ok, init_go;
    logic [32:0]       free_diff;
    logic [EXT_W-1:0]  free_pg;
    logic [33:0]       p_next;
    logic [63:0]       alloc_sum;

    assign i_req.ready = (r_state == pfa_pkg::S_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign slot_free   = !r_o_valid || o_rsp.ready;
    assign any_ne      = |r_ne;

    // Fold an out-of-range CPU index back into the list range
    always_comb begin
        cpu_rem = i_req.cpu;
        for (int k = 0; k < (1 << pfa_pkg::CPU_FLD_W); k++) begin
            if (int'(cpu_rem) >= NUM_CPUS) begin
                cpu_rem = cpu_rem - pfa_pkg::CPU_FLD_W'(NUM_CPUS);
            end
        end
    end

    assign cpu_m = CPU_W'(cpu_rem);

    // Own list first, else lowest-numbered non-empty list
    always_comb begin
        from_sel = '0;
        for (int i = NUM_CPUS - 1; i >= 0; i--) begin
            if (r_ne[i]) begin
                from_sel = CPU_W'(i);
            end
        end
        if (r_ne[cpu_m]) begin
            from_sel = cpu_m;
        end
    end

    // Free address check against the current registers
    assign free_diff = {1'b0, r_addr} - r_base;
    assign free_pg   = EXT_W'(free_diff >> PAGE_BITS);
    assign free_ok   = ((r_addr & PG_MASK[31:0]) == 32'd0)
                    && (r_addr >= r_kernel_end)
                    && (r_addr < r_phys_top)
                    && ({1'b0, r_addr} >= r_base)
                    && (free_pg < EXT_W'(MAX_PAGES));

    // Init walk: one more whole page below phys_top and under the page cap
    assign p_next  = {1'b0, r_p} + PG_SIZE;
    assign init_go = (r_n < N_W'(MAX_PAGES)) && (p_next <= {2'b00, r_phys_top});

    assign alloc_sum = 64'(r_base) + (64'(r_pg) << PAGE_BITS);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pfa_pkg::S_IDLE: begin
                if (accept) begin
                    case (i_req.cmd)
                        pfa_pkg::CMD_ALLOC: n_state = any_ne ? pfa_pkg::S_ALLOC
                                                             : pfa_pkg::S_RESP;
                        pfa_pkg::CMD_FREE:  n_state = pfa_pkg::S_FREE;
                        pfa_pkg::CMD_INIT:  n_state = pfa_pkg::S_INIT;
                        default:            n_state = pfa_pkg::S_RESP;
                    endcase
                end
            end
            pfa_pkg::S_ALLOC: if (slot_free) n_state = pfa_pkg::S_IDLE;
            pfa_pkg::S_FREE:  if (slot_free) n_state = pfa_pkg::S_IDLE;
            pfa_pkg::S_INIT:  if (!init_go) n_state = pfa_pkg::S_RESP;
            pfa_pkg::S_RESP:  if (slot_free) n_state = pfa_pkg::S_IDLE;
            default:          n_state = pfa_pkg::S_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        ram_re     = 1'b0;
        ram_raddr  = r_head[from_sel];
        push_en    = 1'b0;
        push_cpu   = r_cpu;
        push_pg    = free_pg[PGN_W-1:0];
        pop_en     = 1'b0;
        out_load   = 1'b0;
        out_status = pfa_pkg::ST_OK;
        out_addr   = '0;
        out_src    = '0;
        init_clear = 1'b0;
        case (r_state)
            pfa_pkg::S_IDLE: begin
                if (accept && (i_req.cmd == pfa_pkg::CMD_ALLOC) && any_ne) begin
                    ram_re = 1'b1;
                end
                if (accept && (i_req.cmd == pfa_pkg::CMD_INIT)) begin
                    init_clear = 1'b1;
                end
            end
            pfa_pkg::S_ALLOC: begin
                if (slot_free) begin
                    pop_en   = 1'b1;
                    out_load = 1'b1;
                    out_addr = alloc_sum[31:0];
                    out_src  = 3'(r_from);
                end
            end
            pfa_pkg::S_FREE: begin
                if (slot_free) begin
                    out_load   = 1'b1;
                    push_en    = free_ok;
                    out_status = free_ok ? pfa_pkg::ST_OK : pfa_pkg::ST_BAD_FREE;
                end
            end
            pfa_pkg::S_INIT: begin
                push_en  = init_go;
                push_cpu = '0;
                push_pg  = r_n[PGN_W-1:0];
            end
            pfa_pkg::S_RESP: begin
                if (slot_free) begin
                    out_load   = 1'b1;
                    out_status = r_res_status;
                end
            end
            default: ;
        endcase
    end

    // A push links the new page to the old head
    assign ram_we    = push_en;
    assign ram_waddr = push_pg;
    assign ram_wdata = {r_ne[push_cpu], r_head[push_cpu]};

    pfa_ram #(
        .WIDTH (LINK_W),
        .DEPTH (MAX_PAGES)
    ) u_links (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Control state, list heads and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= pfa_pkg::S_IDLE;
            r_o_valid    <= 1'b0;
            r_ne         <= '0;
            r_kernel_end <= pfa_pkg::KERNEL_END_RST;
            r_phys_top   <= pfa_pkg::PHYS_TOP_RST;
            r_base       <= BASE_RST;
            for (int i = 0; i < NUM_CPUS; i++) begin
                r_head[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_o_valid <= 1'b0;
            end
            if (init_clear) begin
                r_ne <= '0;
                for (int i = 0; i < NUM_CPUS; i++) begin
                    r_head[i] <= '0;
                end
            end
            if (push_en) begin
                r_head[push_cpu] <= push_pg;
                r_ne[push_cpu]   <= 1'b1;
            end
            // Pop: follow the link, or empty the list at its tail
            if (pop_en) begin
                r_ne[r_from]   <= ram_rdata[LINK_W-1];
                r_head[r_from] <= ram_rdata[LINK_W-1] ? ram_rdata[PGN_W-1:0] : '0;
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == pfa_pkg::CFG_KERNEL_END) begin
                    r_kernel_end <= i_cfg_data;
                    r_base       <= ({1'b0, i_cfg_data} + PG_MASK) & ~PG_MASK;
                end else if (i_cfg_idx == pfa_pkg::CFG_PHYS_TOP) begin
                    r_phys_top <= i_cfg_data;
                end
            end
        end
    end

    // Working registers and response payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cpu        <= cpu_m;
            r_addr       <= i_req.address;
            r_from       <= from_sel;
            r_pg         <= r_head[from_sel];
            r_p          <= r_base;
            r_n          <= '0;
            r_res_status <= ((i_req.cmd == pfa_pkg::CMD_ALLOC) && !any_ne)
                            ? pfa_pkg::ST_OOM : pfa_pkg::ST_OK;
        end else if ((r_state == pfa_pkg::S_INIT) && init_go) begin
            r_p <= p_next[32:0];
            r_n <= r_n + N_W'(1);
        end
        if (out_load) begin
            r_o_status <= out_status;
            r_o_addr   <= out_addr;
            r_o_src    <= out_src;
        end
    end

    assign o_rsp.valid        = r_o_valid;
    assign o_rsp.status       = r_o_status;
    assign o_rsp.page_address = r_o_addr;
    assign o_rsp.source_cpu   = r_o_src;

endmodule

### src/pfa_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; read data holds while no read is issued.
`timescale 1ns / 1ps

module pfa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
